// ===== hw/rtl/perceptron_train_predict_unit_macros.svh =====
// Assertion helpers for the perceptron unit.
// Both expect clk and arst_n in scope.
`ifndef PERCEPTRON_TRAIN_PREDICT_UNIT_MACROS_SVH
`define PERCEPTRON_TRAIN_PREDICT_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PTP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ptp check failed");
// next-cycle implication
`define PTP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ptp check failed");
`else
`define PTP_ASSERT_NOW(lbl, ante, cons)
`define PTP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/ptp_pkg.sv =====
package ptp_pkg;

	localparam int DIM         = 16;
	localparam int FEAT_W      = 16;
	localparam int WEIGHT_W    = 32;
	localparam int ALPHA_W     = 16;
	localparam int ACC_W       = 64;
	localparam int FRAC_SHIFT  = 12;
	localparam int PROD_W      = FEAT_W + WEIGHT_W;
	localparam int P_W         = ALPHA_W + FEAT_W + 1;
	localparam int R_W         = P_W - FRAC_SHIFT;
	localparam int SUM_W       = WEIGHT_W + 2;
	localparam int CNT_W       = $clog2(DIM + 1);
	localparam int IDX_W       = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] OP_PREDICT = 2'd0;
	localparam logic [1:0] OP_TRAIN   = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;
	localparam logic [1:0] OP_RSVD    = 2'd3;

	localparam logic [ALPHA_W-1:0]         LEARN_RATE_RST = 16'd6554;
	localparam logic signed [WEIGHT_W-1:0] THRESH_RST     = 32'sd65536;

	typedef struct packed {
		logic                     clear;
		logic                     train;
		logic signed [FEAT_W-1:0] x;
		logic                     label;
		logic                     last;
	} item_t;

	typedef struct packed {
		logic too_many_features;
		logic mistake;
		logic prediction;
	} result_t;

	// clamp a two-guard-bit sum to signed 32 bits
	function automatic logic signed [WEIGHT_W-1:0] sat_w(input logic signed [SUM_W-1:0] v);
		logic hi_same;
		hi_same = (v[SUM_W-1:WEIGHT_W-1] == {(SUM_W-WEIGHT_W+1){1'b0}})
			|| (v[SUM_W-1:WEIGHT_W-1] == {(SUM_W-WEIGHT_W+1){1'b1}});
		if (hi_same)
			return v[WEIGHT_W-1:0];
		else if (v[SUM_W-1])
			return {1'b1, {(WEIGHT_W-1){1'b0}}};
		else
			return {1'b0, {(WEIGHT_W-1){1'b1}}};
	endfunction

endpackage

// ===== hw/rtl/ptp_ram.sv =====
module ptp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/ptp_queue.sv =====
module ptp_queue import ptp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output item_t pop_item,
	output logic  nonempty
);

	item_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign pop_item = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_item;
	end

endmodule

// ===== hw/rtl/ptp_front.sv =====
module ptp_front import ptp_pkg::*; (
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [1:0]               operation,
	input  logic signed [FEAT_W-1:0] feature_value,
	input  logic                     label,
	input  logic                     last_feature,
	input  logic                     q_full,
	output logic                     push,
	output item_t                    push_item
);

	logic known_op;

	// reserved op is taken and dropped
	assign known_op = (operation == OP_PREDICT) || (operation == OP_TRAIN)
		|| (operation == OP_CLEAR);
	assign s_tready = !q_full;
	assign push     = s_tvalid && s_tready && known_op;

	always_comb begin
		push_item       = '0;
		push_item.clear = (operation == OP_CLEAR);
		push_item.train = (operation == OP_TRAIN);
		push_item.x     = feature_value;
		push_item.label = label;
		push_item.last  = last_feature;
	end

endmodule

// ===== hw/rtl/ptp_back.sv =====
`include "perceptron_train_predict_unit_macros.svh"

module ptp_back import ptp_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  item_t                      q_item,
	output logic                       q_pop,
	input  logic [ALPHA_W-1:0]         learn_rate,
	input  logic signed [WEIGHT_W-1:0] threshold_init,
	output logic                       res_valid,
	output result_t                    res,
	input  logic                       res_ready
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_MUL     = 3'd1;
	localparam logic [2:0] ST_ADD     = 3'd2;
	localparam logic [2:0] ST_DECIDE  = 3'd3;
	localparam logic [2:0] ST_UPD_RD  = 3'd4;
	localparam logic [2:0] ST_UPD_MUL = 3'd5;
	localparam logic [2:0] ST_UPD_RND = 3'd6;
	localparam logic [2:0] ST_UPD_WR  = 3'd7;

	logic [2:0]                 state_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       ovf_q;
	logic signed [WEIGHT_W-1:0] thr_q;
	logic [DIM-1:0]             wvalid_q;
	logic [CNT_W-1:0]           upd_idx_q, upd_n_q;
	logic                       res_valid_q;
	result_t                    res_q;

	// payload
	logic signed [FEAT_W-1:0]   x_q;
	logic                       label_q, train_q, last_q;
	logic                       wv_s1;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [P_W-1:0]      p_q;
	logic signed [WEIGHT_W-1:0] w_q;
	logic [R_W-1:0]             r_q;
	logic                       neg_q;

	logic                       fire, clear_fire, in_range, res_load;
	logic [IDX_W-1:0]           wt_raddr;
	logic [WEIGHT_W-1:0]        wt_rdata;
	logic [FEAT_W-1:0]          fb_rdata;
	logic                       fb_we, wt_we;
	logic signed [WEIGHT_W-1:0] w_sel;
	logic signed [PROD_W-1:0]   prod_d;
	logic signed [P_W-1:0]      p_d;
	logic [P_W-1:0]             mag;
	logic [P_W:0]               mag_rnd;
	logic signed [ACC_W:0]      sum_acc;
	logic signed [ACC_W-1:0]    acc_d;
	logic signed [ACC_W-1:0]    thr_cmp;
	logic                       pred, miss;
	logic signed [SUM_W-1:0]    w_ext, r_ext, w_sum, thr_ext, a_ext, thr_sum;
	logic signed [WEIGHT_W-1:0] w_new;

	assign fire       = (state_q == ST_IDLE) && q_valid;
	assign q_pop      = fire;
	assign clear_fire = fire && q_item.clear;
	assign in_range   = (cnt_q < CNT_W'(DIM));
	assign fb_we      = fire && !q_item.clear && in_range;
	assign wt_we      = (state_q == ST_UPD_WR);
	assign wt_raddr   = (state_q == ST_IDLE) ? cnt_q[IDX_W-1:0] : upd_idx_q[IDX_W-1:0];

	ptp_ram #(.WIDTH(FEAT_W), .DEPTH(DIM)) u_feat_buf (
		.clk   (clk),
		.we    (fb_we),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata (q_item.x),
		.raddr (upd_idx_q[IDX_W-1:0]),
		.rdata (fb_rdata)
	);

	ptp_ram #(.WIDTH(WEIGHT_W), .DEPTH(DIM)) u_weights (
		.clk   (clk),
		.we    (wt_we),
		.waddr (upd_idx_q[IDX_W-1:0]),
		.wdata (w_new),
		.raddr (wt_raddr),
		.rdata (wt_rdata)
	);

	// never-written weight reads as zero
	assign w_sel  = wv_s1 ? $signed(wt_rdata) : '0;
	assign prod_d = PROD_W'(x_q) * PROD_W'(w_sel);

	assign sum_acc = {acc_q[ACC_W-1], acc_q}
		+ {{(ACC_W + 1 - PROD_W){prod_q[PROD_W-1]}}, prod_q};
	always_comb begin
		if (sum_acc[ACC_W] != sum_acc[ACC_W-1])
			acc_d = sum_acc[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		else
			acc_d = sum_acc[ACC_W-1:0];
	end

	assign thr_cmp = {{(ACC_W - WEIGHT_W - FRAC_SHIFT){thr_q[WEIGHT_W-1]}}, thr_q,
		{FRAC_SHIFT{1'b0}}};
	assign pred     = (acc_q >= thr_cmp);
	assign miss     = (pred != label_q);
	assign res_load = (state_q == ST_DECIDE) && (!res_valid_q || res_ready);

	// threshold moves against the error sign
	assign thr_ext = {{(SUM_W - WEIGHT_W){thr_q[WEIGHT_W-1]}}, thr_q};
	assign a_ext   = SUM_W'(learn_rate);
	assign thr_sum = label_q ? (thr_ext - a_ext) : (thr_ext + a_ext);

	// weight step: alpha*x, Q.28 to Q16.16, round half away from zero
	assign p_d     = P_W'($signed({1'b0, learn_rate})) * P_W'($signed(fb_rdata));
	assign mag     = p_q[P_W-1] ? P_W'(-p_q) : p_q;
	assign mag_rnd = {1'b0, mag} + (P_W+1)'(1 << (FRAC_SHIFT - 1));
	assign w_ext   = {{(SUM_W - WEIGHT_W){w_q[WEIGHT_W-1]}}, w_q};
	assign r_ext   = SUM_W'(r_q);
	assign w_sum   = neg_q ? (w_ext - r_ext) : (w_ext + r_ext);
	assign w_new   = sat_w(w_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			thr_q       <= THRESH_RST;
			wvalid_q    <= '0;
			upd_idx_q   <= '0;
			upd_n_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (clear_fire) begin
						wvalid_q <= '0;
						thr_q    <= threshold_init;
						acc_q    <= '0;
						cnt_q    <= '0;
						ovf_q    <= 1'b0;
					end else if (fire) begin
						if (in_range)
							state_q <= ST_MUL;
						else begin
							ovf_q <= 1'b1;
							if (q_item.last)
								state_q <= ST_DECIDE;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					acc_q   <= acc_d;
					cnt_q   <= cnt_q + 1'b1;
					state_q <= last_q ? ST_DECIDE : ST_IDLE;
				end
				ST_DECIDE: begin
					if (res_load) begin
						acc_q       <= '0;
						cnt_q       <= '0;
						ovf_q       <= 1'b0;
						if (train_q && miss) begin
							thr_q     <= sat_w(thr_sum);
							upd_n_q   <= cnt_q;
							upd_idx_q <= '0;
							state_q   <= ST_UPD_RD;
						end else
							state_q <= ST_IDLE;
					end
				end
				ST_UPD_RD: begin
					state_q <= ST_UPD_MUL;
				end
				ST_UPD_MUL: begin
					state_q <= ST_UPD_RND;
				end
				ST_UPD_RND: begin
					state_q <= ST_UPD_WR;
				end
				ST_UPD_WR: begin
					wvalid_q[upd_idx_q[IDX_W-1:0]] <= 1'b1;
					upd_idx_q <= upd_idx_q + 1'b1;
					state_q   <= (upd_idx_q + 1'b1 == upd_n_q) ? ST_IDLE : ST_UPD_RD;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register: a new result may replace one being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (res_load)
			res_valid_q <= 1'b1;
		else if (res_ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		wv_s1 <= wvalid_q[wt_raddr];
		if (fire) begin
			x_q     <= q_item.x;
			label_q <= q_item.label;
			train_q <= q_item.train;
			last_q  <= q_item.last;
		end
		if (state_q == ST_MUL)
			prod_q <= prod_d;
		if (state_q == ST_UPD_MUL) begin
			p_q <= p_d;
			w_q <= w_sel;
		end
		if (state_q == ST_UPD_RND) begin
			r_q   <= mag_rnd[P_W-1:FRAC_SHIFT];
			neg_q <= p_q[P_W-1] ^ !label_q;
		end
		if (res_load) begin
			res_q.prediction        <= pred;
			res_q.mistake           <= miss;
			res_q.too_many_features <= ovf_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`PTP_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(DIM))
	`PTP_ASSERT_NOW(a_upd_idx_bound, state_q == ST_UPD_RD, upd_idx_q < upd_n_q)
	`PTP_ASSERT_NEXT(a_acc_cleared, res_load, acc_q == '0)
	`PTP_ASSERT_NOW(a_thr_only_on_event, $past(state_q) != ST_DECIDE && !$past(clear_fire), $stable(thr_q))

endmodule

// ===== hw/rtl/perceptron_train_predict_unit.sv =====
// Channel   Dir  Accepted when              Payload
// s_*       in   s_tvalid & s_tready        tdata feature/label, tuser op, tlast end
// m_*       out  m_tvalid & m_tready        tdata prediction/mistake/too_many
// APB       in   psel & penable & pwrite    0x0 learn_rate, 0x4 threshold_init
//
// A feature transfer passes the back end as weight read, multiply and saturating
// accumulate; the closing one adds a decide step, and a clear is taken in idle.
// A training mistake adds an update pass over each buffered feature:
// registered weight/feature read, step multiply, rounding, write back.
// The 2-entry queue lets the input side run ahead while the back end works.
// Reset clears control state and the per-weight valid bits; no clearing pass.
// The result register holds until taken; the back end waits in decide meanwhile.
module perceptron_train_predict_unit import ptp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [15:0] feature_value, [16] label, [23:17] zero
	input  logic [1:0]  s_tuser,  // [1:0] operation
	input  logic        s_tlast,  // last_feature
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [0] prediction, [1] mistake, [2] too_many_features
	// config
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [ALPHA_W-1:0]         learn_rate_q;
	logic signed [WEIGHT_W-1:0] threshold_init_q;
	logic                       cfg_wr;

	item_t   push_item, pop_item;
	logic    push, q_full, q_pop, q_nonempty;
	result_t res;

	// --- config registers: word index from paddr[2]
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_rate_q     <= LEARN_RATE_RST;
			threshold_init_q <= THRESH_RST;
		end else if (cfg_wr) begin
			if (paddr[2])
				threshold_init_q <= pwdata;
			else
				learn_rate_q <= pwdata[ALPHA_W-1:0];
		end
	end

	assign prdata = paddr[2] ? threshold_init_q : 32'(learn_rate_q);

	// --- front: classify, drop reserved op
	ptp_front u_front (
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.operation     (s_tuser),
		.feature_value (s_tdata[FEAT_W-1:0]),
		.label         (s_tdata[FEAT_W]),
		.last_feature  (s_tlast),
		.q_full        (q_full),
		.push          (push),
		.push_item     (push_item)
	);

	// --- decoupling queue
	ptp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.nonempty  (q_nonempty)
	);

	// --- back: accumulate, decide, learn
	ptp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_nonempty),
		.q_item         (pop_item),
		.q_pop          (q_pop),
		.learn_rate     (learn_rate_q),
		.threshold_init (threshold_init_q),
		.res_valid      (m_tvalid),
		.res            (res),
		.res_ready      (m_tready)
	);

	assign m_tdata = {5'b0, res};

endmodule

// ===== dv/perceptron_train_predict_unit_test.sv =====
module perceptron_train_predict_unit_test;
	import ptp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// register byte addresses on the APB port
	localparam logic [2:0] REG_LEARN_RATE  = 3'h0;
	localparam logic [2:0] REG_THRESH_INIT = 3'h4;

	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 205;   // random feature transfers per phase
	localparam int DRAIN_CYCLES = 120;   // covers the longest update pass, over DIM features, plus queue
	localparam int QUIET_LIMIT  = 5000;  // cycles with no transfer before giving up
	localparam int PRESSURE_AT  = 25;    // result count that starts the long back-pressure
	localparam int PRESSURE_LEN = 700;

	localparam int     W_MAX  = 32'sh7fff_ffff;
	localparam int     W_MIN  = 32'sh8000_0000;
	localparam longint DOT_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam longint DOT_MIN = 64'sh8000_0000_0000_0000;

	// one feature transfer as the sender sees it
	typedef struct packed {
		logic [1:0]               op;
		logic signed [FEAT_W-1:0] x;
		logic                     label;
		logic                     last;
	} feat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // [15:0] feature_value, [16] label, [23:17] zero
	logic [1:0]  s_tuser = '0;   // [1:0] operation
	logic        s_tlast = 1'b0; // last_feature
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // [0] prediction, [1] mistake, [2] too_many_features
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	perceptron_train_predict_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// ------------------------------------------------------------------
	// Mirror of the perceptron: weights, threshold, sample accumulator
	// ------------------------------------------------------------------
	logic [ALPHA_W-1:0]       alpha_mirror;
	int                       thr_init_mirror;
	int                       w_mirror [DIM];
	int                       thr_mirror;
	logic signed [FEAT_W-1:0] fbuf_mirror [DIM];
	longint                   dot_mirror;
	int                       cnt_mirror;
	bit                       extra_mirror;

	feat_t   pending_feats [$];  // fed by the sequencer, drained by the driver
	result_t verdicts_due  [$];  // predicted results, oldest first

	feat_t   on_bus;
	result_t want;
	int      send_gap, hold_off, quiet;
	bit      sender_eager, taker_eager;
	int      faults, n_sent, n_taken, n_updates, n_overflow, n_clears;

	function automatic int clamp32(input longint v);
		if (v > longint'(W_MAX))
			return W_MAX;
		if (v < longint'(W_MIN))
			return W_MIN;
		return int'(v);
	endfunction

	// alpha * x in Q.28, brought to Q16.16 rounding half away from zero
	function automatic longint alpha_step(input logic signed [FEAT_W-1:0] x);
		longint p, mag;
		p = longint'(alpha_mirror) * longint'(x);
		mag = (p < 0) ? -p : p;
		mag = (mag + 2048) >> FRAC_SHIFT;
		return (p < 0) ? -mag : mag;
	endfunction

	function automatic void end_sample();
		dot_mirror = 0;
		cnt_mirror = 0;
		extra_mirror = 1'b0;
	endfunction

	// apply one accepted feature transfer; queue a result on a closing item
	function automatic void absorb_transfer(input feat_t t);
		longint prod, sum, step;
		result_t r;
		int i;
		if (t.op == OP_RSVD)
			return;
		if (t.op == OP_CLEAR) begin
			for (i = 0; i < DIM; i++)
				w_mirror[i] = 0;
			thr_mirror = thr_init_mirror;
			end_sample();
			n_clears++;
			return;
		end
		if (cnt_mirror < DIM) begin
			fbuf_mirror[cnt_mirror] = t.x;
			prod = longint'(t.x) * longint'(w_mirror[cnt_mirror]);
			sum = dot_mirror + prod;
			if (prod > 0 && sum < dot_mirror)
				sum = DOT_MAX;
			else if (prod < 0 && sum > dot_mirror)
				sum = DOT_MIN;
			dot_mirror = sum;
			cnt_mirror++;
		end else begin
			extra_mirror = 1'b1;
		end
		if (!t.last)
			return;
		// threshold is Q16.16, dot is Q.28: compare exactly by scaling
		r.prediction = (dot_mirror >= longint'(thr_mirror) * 4096);
		r.mistake = (r.prediction != t.label);
		r.too_many_features = extra_mirror;
		if (t.op == OP_TRAIN && r.mistake) begin
			for (i = 0; i < cnt_mirror; i++) begin
				step = alpha_step(fbuf_mirror[i]);
				w_mirror[i] = clamp32(longint'(w_mirror[i]) + (t.label ? step : -step));
			end
			thr_mirror = clamp32(longint'(thr_mirror)
				+ (t.label ? -longint'(alpha_mirror) : longint'(alpha_mirror)));
			n_updates++;
		end
		if (extra_mirror)
			n_overflow++;
		verdicts_due.push_back(r);
		end_sample();
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// extremes and near-zero values show up more often than pure chance gives
	function automatic logic signed [FEAT_W-1:0] rand_feature();
		case ($urandom_range(0, 9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return FEAT_W'($urandom_range(0, 16)) - 16'sd8;
			default: return FEAT_W'($urandom);
		endcase
	endfunction

	function automatic void check_field(input string name, input bit exp_v, input bit got);
		if (exp_v !== got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, got);
			faults++;
		end
	endfunction

	// ------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------
	initial begin
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Driver: presents queued features; the mirror is updated at acceptance
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			s_tlast <= 1'b0;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				absorb_transfer(on_bus);
				n_sent++;
			end
			// bus is free once the current transfer has gone (or nothing is offered)
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_feats.size() > 0) begin
					on_bus = pending_feats.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {7'd0, on_bus.label, on_bus.x};
					s_tuser <= on_bus.op;
					s_tlast <= on_bus.last;
					if (!sender_eager)
						send_gap = pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each result transfer, and throttles m_tready.
	// One long hold-off lets the output register and the input queue fill
	// while the sender keeps offering.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_off = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (verdicts_due.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual tdata 0x%02h",
						$time, m_tdata);
					faults++;
				end else begin
					want = verdicts_due.pop_front();
					check_field("prediction", want.prediction, m_tdata[0]);
					check_field("mistake", want.mistake, m_tdata[1]);
					check_field("too_many_features", want.too_many_features, m_tdata[2]);
				end
				n_taken++;
				if (n_taken == PRESSURE_AT)
					hold_off = PRESSURE_LEN;
			end
			if (hold_off > 0) begin
				hold_off--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!taker_eager)
					hold_off = pick_gap();
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: any transfer on either stream or the APB port restarts it
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d results outstanding",
					$time, QUIET_LIMIT, verdicts_due.size());
				$display("CHECKS FAILED");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// APB access: setup cycle, access cycle; write/read lands on the edge
	// where psel and penable are both high
	// ------------------------------------------------------------------
	task automatic apb_xfer(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (wr) begin
			case (addr)
				REG_LEARN_RATE:  alpha_mirror = wdata[ALPHA_W-1:0];
				REG_THRESH_INIT: thr_init_mirror = wdata;
				default: ;
			endcase
		end
	endtask

	task automatic check_register(input logic [2:0] addr);
		logic [31:0] got, exp_v;
		apb_xfer(1'b0, addr, '0, got);
		exp_v = (addr == REG_LEARN_RATE) ? {16'd0, alpha_mirror} : thr_init_mirror;
		if (got !== exp_v) begin
			$display("%0t: register 0x%0h readback mismatch: expected 0x%08h, actual 0x%08h",
				$time, addr, exp_v, got);
			faults++;
		end
	endtask

	// learn_rate writes carry junk in the unused upper half
	task automatic set_registers(input logic [ALPHA_W-1:0] lr, input logic [31:0] ti);
		logic [31:0] unused;
		apb_xfer(1'b1, REG_LEARN_RATE, {16'($urandom), lr}, unused);
		apb_xfer(1'b1, REG_THRESH_INIT, ti, unused);
		check_register(REG_LEARN_RATE);
		check_register(REG_THRESH_INIT);
	endtask

	// idle = nothing queued, nothing offered, nothing owed; then let a
	// trailing clear or update pass finish
	task automatic settle();
		@(negedge clk);
		while (pending_feats.size() != 0 || s_tvalid || verdicts_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void push_feat(input logic [1:0] op, input logic signed [FEAT_W-1:0] x,
		input bit label, input bit last);
		feat_t t;
		t.op = op;
		t.x = x;
		t.label = label;
		t.last = last;
		pending_feats.push_back(t);
	endfunction

	// one sample with random content; now and then an over-long one, a stray
	// reserved op, a clear dropped in the middle, or a clear before it
	function automatic int queue_random_sample();
		int len, k, n;
		logic [1:0] close_op;
		n = 0;
		if ($urandom_range(0, 32) == 0) begin
			push_feat(OP_CLEAR, rand_feature(), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
			n++;
		end
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(DIM + 1, DIM + 4)
			: $urandom_range(1, DIM);
		close_op = $urandom_range(0, 2) ? OP_TRAIN : OP_PREDICT;
		for (k = 0; k < len; k++) begin
			if ($urandom_range(0, 29) == 0)
				push_feat(OP_RSVD, rand_feature(), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			if (k == len - 1) begin
				push_feat(close_op, rand_feature(), 1'($urandom_range(0, 1)), 1'b1);
			end else begin
				if ($urandom_range(0, 59) == 0) begin
					push_feat(OP_CLEAR, rand_feature(), 1'($urandom_range(0, 1)), 1'b0);
					n++;
				end
				push_feat($urandom_range(0, 1) ? OP_TRAIN : OP_PREDICT, rand_feature(),
					1'($urandom_range(0, 1)), 1'b0);
			end
			n++;
		end
		return n;
	endfunction

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	initial begin
		int ph, k, budget;
		alpha_mirror = LEARN_RATE_RST;
		thr_init_mirror = THRESH_RST;
		thr_mirror = THRESH_RST;
		for (k = 0; k < DIM; k++) begin
			w_mirror[k] = 0;
			fbuf_mirror[k] = '0;
		end
		end_sample();
		sender_eager = 1'b0;
		taker_eager = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_register(REG_LEARN_RATE);
		check_register(REG_THRESH_INIT);

		for (ph = 0; ph < PHASES; ph++) begin
			budget = 0;
			if (ph == 0) begin
				// reserved op, lone features both ways, train up and down
				push_feat(OP_RSVD, 16'sh1234, 1'b1, 1'b1);
				push_feat(OP_PREDICT, 16'sh7fff, 1'b1, 1'b1);
				push_feat(OP_TRAIN, 16'sh7fff, 1'b1, 1'b1);
				push_feat(OP_TRAIN, 16'sh8000, 1'b0, 1'b1);
				// DIM+1 features, mixed ops; only the closing op counts
				for (k = 0; k <= DIM; k++)
					push_feat((k % 2) ? OP_TRAIN : OP_PREDICT, (k % 2) ? 16'sh8000 : 16'sh7fff,
						1'b0, k == DIM);
				// clear drops the open sample, no result for it
				push_feat(OP_TRAIN, 16'sh0001, 1'b1, 1'b0);
				push_feat(OP_CLEAR, 16'sh0000, 1'b0, 1'b0);
				push_feat(OP_PREDICT, 16'shffff, 1'b0, 1'b1);
			end else begin
				settle();
				case (ph)
					1: set_registers(16'hffff, 32'h8000_0000);
					2: set_registers(16'h0000, 32'h7fff_ffff);
					3: set_registers(16'($urandom), 32'h0000_0000);
					4: set_registers(16'($urandom_range(1, 65535)), $urandom);
					default: set_registers(16'($urandom_range(1, 16384)),
						32'($urandom_range(0, 262144)) - 32'd131072);
				endcase
				push_feat(OP_CLEAR, 16'sh0000, 1'b0, 1'b0);
			end
			// one phase with the sender at full rate, two with the receiver always ready
			sender_eager = (ph == 3);
			taker_eager = (ph == 3 || ph == 4);
			while (budget < PHASE_ITEMS)
				budget += queue_random_sample();
		end

		settle();
		$display("Covered %0d feature transfers over %0d register settings: %0d results,",
			n_sent, PHASES, n_taken);
		$display("  %0d training updates, %0d over-long samples, %0d clears.",
			n_updates, n_overflow, n_clears);
		if (faults == 0 && verdicts_due.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
